FILE: rtl/core/rgc_pkg.sv
// ============================================================================
// rgc_pkg - shared types, constants and byte classifiers
// Character codes, controller state and command types, and the byte tests
// used by the readability grade counter.
// ============================================================================
package rgc_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int CH_W           = 8;
    localparam int GRADE_W        = 40;
    localparam int WSYL_W         = 8;
    localparam int LEN_W          = 2;

    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CH_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CH_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;

    localparam logic [LEN_W-1:0]  LEN_MAX  = 2'd3;
    localparam logic [WSYL_W-1:0] WSYL_MAX = 8'hFF;

    typedef enum logic [3:0] {
        ST_SCAN,
        ST_MUL_SW,
        ST_ACC_SW,
        ST_MUL_WW,
        ST_ACC_WW,
        ST_MUL_YS,
        ST_ACC_YS,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN
    } t_state;

    // Which product term the multiplier and accumulator work on
    typedef enum logic [1:0] {
        OP_SW,
        OP_WW,
        OP_YS
    } t_op;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic acc_en;
        t_op  op;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;

    function automatic logic is_letter(input logic [CH_W-1:0] ch);
        return ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_word_byte(input logic [CH_W-1:0] ch);
        return is_letter(ch) || (ch inside {[8'h30:8'h39], CH_UNDER, CH_APOS});
    endfunction

    function automatic logic is_vowel(input logic [CH_W-1:0] ch);
        return ch inside {8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h79,
                          8'h41, 8'h45, 8'h49, 8'h4F, 8'h55, 8'h59};
    endfunction

    function automatic logic is_sentence_mark(input logic [CH_W-1:0] ch);
        return ch inside {CH_DOT, CH_BANG, CH_QUEST};
    endfunction

endpackage

FILE: rtl/core/rgc_ctrl.sv
// ============================================================================
// rgc_ctrl - sequencing controller
// Steps the datapath through scanning, the three product terms, the serial
// divide and the result load; owns both handshakes.
// ============================================================================
module rgc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rgc_pkg::t_status i_status,
    output rgc_pkg::t_cmd    o_cmd
);

    rgc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    // result register free now or emptied at this edge
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgc_pkg::ST_SCAN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rgc_pkg::ST_SCAN:     if (i_valid && i_last) n_state = rgc_pkg::ST_MUL_SW;
            rgc_pkg::ST_MUL_SW:   n_state = rgc_pkg::ST_ACC_SW;
            rgc_pkg::ST_ACC_SW:   n_state = rgc_pkg::ST_MUL_WW;
            rgc_pkg::ST_MUL_WW:   n_state = rgc_pkg::ST_ACC_WW;
            rgc_pkg::ST_ACC_WW:   n_state = rgc_pkg::ST_MUL_YS;
            rgc_pkg::ST_MUL_YS:   n_state = rgc_pkg::ST_ACC_YS;
            rgc_pkg::ST_ACC_YS:   n_state = rgc_pkg::ST_DIV_INIT;
            rgc_pkg::ST_DIV_INIT: n_state = rgc_pkg::ST_DIV;
            rgc_pkg::ST_DIV:      if (i_status.div_last) n_state = rgc_pkg::ST_FIN;
            rgc_pkg::ST_FIN:      if (w_out_free) n_state = rgc_pkg::ST_SCAN;
            default:              n_state = rgc_pkg::ST_SCAN;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_cmd.op = rgc_pkg::OP_SW;
        case (r_state)
            rgc_pkg::ST_SCAN:   o_cmd.accept = i_valid;
            rgc_pkg::ST_MUL_SW: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_SW;
            end
            rgc_pkg::ST_ACC_SW: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_SW;
            end
            rgc_pkg::ST_MUL_WW: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_WW;
            end
            rgc_pkg::ST_ACC_WW: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_WW;
            end
            rgc_pkg::ST_MUL_YS: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_YS;
            end
            rgc_pkg::ST_ACC_YS: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.op     = rgc_pkg::OP_YS;
            end
            rgc_pkg::ST_DIV_INIT: o_cmd.div_init = 1'b1;
            rgc_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            rgc_pkg::ST_FIN:      o_cmd.out_load = w_out_free;
            default:              o_cmd.accept   = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != rgc_pkg::ST_SCAN);
    assign o_valid = r_out_valid;

endmodule

FILE: rtl/core/rgc_datapath.sv
// ============================================================================
// rgc_datapath - text scanner and grade arithmetic
// Word, sentence and syllable counting per byte; shared multiplier,
// numerator accumulator, restoring divider and result registers.
// ============================================================================
module rgc_datapath #(
    parameter int COUNT_BITS = rgc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = rgc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rgc_pkg::t_cmd                     i_cmd,
    output rgc_pkg::t_status                  o_status,
    input  logic [rgc_pkg::CH_W-1:0]          i_ch,
    input  logic                              i_last,
    output logic [COUNT_BITS-1:0]             o_word_total,
    output logic [COUNT_BITS-1:0]             o_sentence_total,
    output logic [COUNT_BITS-1:0]             o_syllable_total,
    output logic signed [rgc_pkg::GRADE_W-1:0] o_grade_q8
);

    localparam int QB     = COUNT_BITS + FRAC_BITS + 4;
    localparam int PROD_W = 2 * COUNT_BITS;
    localparam int DEN_W  = PROD_W + 7;
    localparam int NUM_W  = DEN_W + QB;
    localparam int CNT_W  = $clog2(QB);
    localparam int EXT_W  = (QB + 1 > rgc_pkg::GRADE_W + 2) ? QB + 1 : rgc_pkg::GRADE_W + 2;
    localparam int GW     = rgc_pkg::GRADE_W;

    // numerator = 2^F*(41*SW + 39*WW + 1180*YS) + 50*SW, divisor = 100*SW,
    // quotient carries an offset of 16 grade units so it stays non-negative
    localparam logic [NUM_W-1:0] K_SW  = NUM_W'((41 << FRAC_BITS) + 50);
    localparam logic [NUM_W-1:0] K_WW  = NUM_W'(39 << FRAC_BITS);
    localparam logic [NUM_W-1:0] K_YS  = NUM_W'(1180 << FRAC_BITS);
    localparam logic [DEN_W-1:0] K_DEN = DEN_W'(100);
    localparam logic [EXT_W-1:0] G_OFFSET = EXT_W'(16) << FRAC_BITS;
    localparam logic [EXT_W-1:0] G_LIMIT  =
        ((EXT_W'(1) << (GW - 1)) - EXT_W'(1)) + G_OFFSET;
    localparam logic [GW-1:0]    G_MAX = {1'b0, {(GW - 1){1'b1}}};

    // scanner state
    logic                        r_in_word, r_word_counts, r_in_vowel, r_ends_e;
    logic [rgc_pkg::LEN_W-1:0]   r_len;
    logic [rgc_pkg::WSYL_W-1:0]  r_wsyl;
    logic [COUNT_BITS-1:0]       r_words, r_sents, r_syls;

    // arithmetic state
    logic [COUNT_BITS-1:0]       r_opw, r_ops, r_opy;
    logic [PROD_W-1:0]           r_prod;
    logic [NUM_W-1:0]            r_num;
    logic [DEN_W-1:0]            r_den;
    logic [DEN_W-1:0]            r_rem;
    logic [QB-1:0]               r_quo;
    logic [CNT_W-1:0]            r_cnt;

    // scanner next values
    logic                        w_word, w_do_end, w_add_word;
    logic                        p_in_word, p_counts, p_vowel, p_e;
    logic [rgc_pkg::LEN_W-1:0]   p_len;
    logic [rgc_pkg::WSYL_W-1:0]  p_syl, w_adj;
    logic [COUNT_BITS:0]         w_words_sum, w_sents_sum, w_syls_sum;
    logic [COUNT_BITS-1:0]       n_words, n_sents, n_syls;

    logic [COUNT_BITS-1:0]       w_mul_a, w_mul_b;
    logic [DEN_W:0]              w_trial;
    logic [EXT_W-1:0]            w_q_ext;
    logic [GW-1:0]               w_grade;

    always_comb begin
        w_word    = rgc_pkg::is_word_byte(i_ch);
        p_in_word = r_in_word;
        p_counts  = r_word_counts;
        p_vowel   = r_in_vowel;
        p_len     = r_len;
        p_syl     = r_wsyl;
        p_e       = r_ends_e;
        if (w_word) begin
            if (!r_in_word) begin
                p_in_word = 1'b1;
                p_counts  = rgc_pkg::is_letter(i_ch);
                p_vowel   = 1'b0;
                p_len     = '0;
                p_syl     = '0;
            end
            if (p_len != rgc_pkg::LEN_MAX) p_len = p_len + 2'd1;
            if (rgc_pkg::is_vowel(i_ch)) begin
                if (!p_vowel && p_syl != rgc_pkg::WSYL_MAX) p_syl = p_syl + 8'd1;
                p_vowel = 1'b1;
            end else begin
                p_vowel = 1'b0;
            end
            p_e = (i_ch == rgc_pkg::CH_LOW_E);
        end
        // a non-word byte or the final byte closes the open word
        w_do_end   = !w_word || i_last;
        w_add_word = w_do_end && p_in_word && p_counts;
        w_adj      = p_syl;
        if (p_len == rgc_pkg::LEN_MAX && p_e && p_syl > 8'd1) w_adj = p_syl - 8'd1;

        w_words_sum = {1'b0, r_words} + (COUNT_BITS + 1)'(1);
        w_syls_sum  = {1'b0, r_syls} + (COUNT_BITS + 1)'(w_adj);
        w_sents_sum = {1'b0, r_sents} + (COUNT_BITS + 1)'(1);

        n_words = r_words;
        n_syls  = r_syls;
        n_sents = r_sents;
        if (w_add_word) begin
            n_words = w_words_sum[COUNT_BITS] ? '1 : w_words_sum[COUNT_BITS-1:0];
            n_syls  = w_syls_sum[COUNT_BITS]  ? '1 : w_syls_sum[COUNT_BITS-1:0];
        end
        if (!w_word && rgc_pkg::is_sentence_mark(i_ch)) begin
            n_sents = w_sents_sum[COUNT_BITS] ? '1 : w_sents_sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word     <= 1'b0;
            r_word_counts <= 1'b0;
            r_in_vowel    <= 1'b0;
            r_ends_e      <= 1'b0;
            r_len         <= '0;
            r_wsyl        <= '0;
            r_words       <= '0;
            r_sents       <= '0;
            r_syls        <= '0;
        end else if (i_cmd.accept) begin
            if (i_last) begin
                r_in_word     <= 1'b0;
                r_word_counts <= 1'b0;
                r_in_vowel    <= 1'b0;
                r_ends_e      <= 1'b0;
                r_len         <= '0;
                r_wsyl        <= '0;
                r_words       <= '0;
                r_sents       <= '0;
                r_syls        <= '0;
            end else begin
                r_in_word     <= p_in_word && !w_do_end;
                r_word_counts <= p_counts && !w_do_end;
                r_in_vowel    <= p_vowel && !w_do_end;
                r_ends_e      <= p_e && !w_do_end;
                r_len         <= w_do_end ? '0 : p_len;
                r_wsyl        <= w_do_end ? '0 : p_syl;
                r_words       <= n_words;
                r_sents       <= n_sents;
                r_syls        <= n_syls;
            end
        end
    end

    // operands: empty totals of words and sentences count as one
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_opw <= (n_words == '0) ? COUNT_BITS'(1) : n_words;
            r_ops <= (n_sents == '0) ? COUNT_BITS'(1) : n_sents;
            r_opy <= n_syls;
        end
    end

    always_comb begin
        w_mul_a = r_ops;
        w_mul_b = r_opw;
        case (i_cmd.op)
            rgc_pkg::OP_SW: begin
                w_mul_a = r_ops;
                w_mul_b = r_opw;
            end
            rgc_pkg::OP_WW: begin
                w_mul_a = r_opw;
                w_mul_b = r_opw;
            end
            rgc_pkg::OP_YS: begin
                w_mul_a = r_opy;
                w_mul_b = r_ops;
            end
            default: begin
                w_mul_a = r_ops;
                w_mul_b = r_opw;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.op)
                rgc_pkg::OP_SW: begin
                    r_num <= NUM_W'(r_prod) * K_SW;
                    r_den <= DEN_W'(r_prod) * K_DEN;
                end
                rgc_pkg::OP_WW: r_num <= r_num + NUM_W'(r_prod) * K_WW;
                rgc_pkg::OP_YS: r_num <= r_num + NUM_W'(r_prod) * K_YS;
                default:        r_num <= r_num;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[QB-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= DEN_W'(r_num >> QB);
            r_quo <= r_num[QB-1:0];
            r_cnt <= CNT_W'(QB - 1);
        end else if (i_cmd.div_step) begin
            if (!w_trial[DEN_W]) begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quo <= {r_quo[QB-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DEN_W-2:0], r_quo[QB-1]};
                r_quo <= {r_quo[QB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_status.div_last = (r_cnt == '0);

    // drop the offset and clamp at the top of the signed range
    always_comb begin
        w_q_ext = EXT_W'(r_quo);
        if (w_q_ext > G_LIMIT) begin
            w_grade = G_MAX;
        end else begin
            w_grade = GW'(w_q_ext - G_OFFSET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_word_total     <= r_opw;
            o_sentence_total <= r_ops;
            o_syllable_total <= r_opy;
            o_grade_q8       <= w_grade;
        end
    end

endmodule

FILE: rtl/core/readability_grade_counter.sv
// ============================================================================
// readability_grade_counter - text readability grade level
// Counts words, sentence marks and syllables over a byte stream and gives
// the totals with the grade level in signed fixed point.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall, payload i_ch, i_last): one byte per
//   request. While scanning, o_stall is low and a byte is taken every cycle.
//   A request with i_last high closes the text; o_stall then rises and stays
//   high while the grade is computed.
//   Output channel (o_valid / i_stall): one result request per text, holding
//   word, sentence and syllable totals and the grade times 2^FRAC_BITS.
//   After the last byte is taken, the three products are built on the shared
//   multiplier, each with a multiply and an accumulate state; the divider is
//   then loaded, the restoring divider retires one quotient bit a cycle,
//   COUNT_BITS + FRAC_BITS + 4 bits in all, and the result is loaded.
//   Throughput: one byte per cycle inside a text; input is held off at the
//   end of each text until its result has been loaded.
//   A stalled result holds in the output register; scanning of the next text
//   goes on, and a finished grade waits until that register is free.
//   Reset clears the scanner counters, the controller and o_valid.
// ============================================================================
module readability_grade_counter #(
    parameter int COUNT_BITS = rgc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = rgc_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rgc_pkg::CH_W-1:0]           i_ch,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [COUNT_BITS-1:0]              o_word_total,
    output logic [COUNT_BITS-1:0]              o_sentence_total,
    output logic [COUNT_BITS-1:0]              o_syllable_total,
    output logic signed [rgc_pkg::GRADE_W-1:0] o_grade_q8
);

    // command from the controller, status back from the datapath
    rgc_pkg::t_cmd    w_cmd;
    rgc_pkg::t_status w_status;

    rgc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // scanner counters, shared multiplier, serial divider, result registers
    rgc_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_ch             (i_ch),
        .i_last           (i_last),
        .o_word_total     (o_word_total),
        .o_sentence_total (o_sentence_total),
        .o_syllable_total (o_syllable_total),
        .o_grade_q8       (o_grade_q8)
    );

endmodule

FILE: rtl/core/rgc_checker.sv
// ============================================================================
// rgc_checker - port-level checks
// Watches the top-level ports for handshake and result sanity.
// ============================================================================
module rgc_checker #(
    parameter int COUNT_BITS = rgc_pkg::COUNT_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [rgc_pkg::CH_W-1:0]           i_ch,
    input logic                               i_last,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [COUNT_BITS-1:0]              o_word_total,
    input logic [COUNT_BITS-1:0]              o_sentence_total,
    input logic [COUNT_BITS-1:0]              o_syllable_total,
    input logic signed [rgc_pkg::GRADE_W-1:0] o_grade_q8
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grade_q8) && $stable(o_word_total)
            && $stable(o_sentence_total) && $stable(o_syllable_total))
        else $error("stalled result dropped or changed");

    // hold a stalled input request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_ch) && $stable(i_last))
        else $error("stalled input request dropped or changed");

    a_totals_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word_total != '0) && (o_sentence_total != '0))
        else $error("word or sentence total is zero");

    // the final byte starts the grade computation, which holds off input
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input not held off after final byte");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind readability_grade_counter rgc_checker #(.COUNT_BITS(COUNT_BITS)) u_rgc_checker (.*);
